[rtl/jac_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the joystick axis conditioner
// no dependencies; used by every module under rtl except jac_div

package jac_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int DEAD_W     = 7;
	localparam int POS_W      = 8;
	localparam int SENS_W     = 6;
	localparam int CFG_ADDR_W = 5;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;

	// filter coefficients, unsigned q0.16
	localparam logic [15:0] ALPHA_Q16     = 16'd13107;
	localparam logic [15:0] ONE_MINUS_Q16 = 16'd52429;

	// mapping onto -OUT_SPAN..+OUT_SPAN
	localparam int OUT_SPAN   = 100;
	localparam int MAP_NUM_W  = 20;
	localparam logic [8:0] MAP_SCALE = 9'(2 * OUT_SPAN);

	// pot mapping onto 1..50
	localparam int POT_NUM_W = 18;
	localparam logic [5:0] POT_SCALE = 6'd49;
	localparam logic [SENS_W-1:0] SENS_MIN = 6'd1;

	// register reset values
	localparam logic [SAMPLE_W-1:0] RST_LOW    = 12'd0;
	localparam logic [SAMPLE_W-1:0] RST_HIGH   = 12'd4095;
	localparam logic [SAMPLE_W-1:0] RST_REST   = 12'd2048;
	localparam logic [DEAD_W-1:0]   RST_X_DEAD = 7'd20;
	localparam logic [DEAD_W-1:0]   RST_Y_DEAD = 7'd25;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_LOW  = 3'd0,
		REG_X_HIGH = 3'd1,
		REG_Y_LOW  = 3'd2,
		REG_Y_HIGH = 3'd3,
		REG_X_REST = 3'd4,
		REG_Y_REST = 3'd5,
		REG_X_DEAD = 3'd6,
		REG_Y_DEAD = 3'd7
	} cfg_idx_e;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} top_state_e;

	typedef enum logic [2:0] {
		LS_IDLE,
		LS_MUL,
		LS_ADD,
		LS_PRE,
		LS_DIV,
		LS_POST,
		LS_DONE
	} lane_state_e;

	typedef struct packed {
		logic [SAMPLE_W-1:0] raw_x;
		logic [SAMPLE_W-1:0] raw_y;
		logic                button_level;
		logic [SAMPLE_W-1:0] pot_level;
	} in_item_t;

	typedef struct packed {
		logic signed [POS_W-1:0] x_position;
		logic signed [POS_W-1:0] y_position;
		logic                    button_state;
		logic [SENS_W-1:0]       sensitivity_level;
	} out_item_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] lo;
		logic [SAMPLE_W-1:0] hi;
		logic [DEAD_W-1:0]   dead;
	} axis_cfg_t;

	typedef struct packed {
		logic                start;
		logic                load;
		logic [SAMPLE_W-1:0] rest;
	} lane_ctl_t;

endpackage

[rtl/jac_div.sv]
`timescale 1ns / 1ps
// restoring serial divider, one quotient bit per cycle
// uses no package items

module jac_div #(
	parameter int NUM_W = 20,
	parameter int DEN_W = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numer,
	input  logic [DEN_W-1:0] denom,
	output logic             busy,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] work_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   trial;
	logic             take;

	assign trial = {rem_q, work_q[NUM_W-1]};
	assign take  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			busy_q <= cnt_q != CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			den_q  <= denom;
			work_q <= numer;
		end else if (busy_q) begin
			rem_q  <= take ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			work_q <= {work_q[NUM_W-2:0], take};
		end
	end

	assign busy = busy_q;
	assign quot = work_q;

endmodule

[rtl/jac_lane.sv]
`timescale 1ns / 1ps
// one axis lane: exponential filter state, range map, clamp and dead band
// depends on jac_pkg and jac_div

module jac_lane #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  jac_pkg::lane_ctl_t                  ctl,
	input  jac_pkg::axis_cfg_t                  cfg,
	input  logic [jac_pkg::SAMPLE_W-1:0]        raw,
	output logic                                done,
	output logic signed [jac_pkg::POS_W-1:0]    result
);

	localparam int SB = jac_pkg::SAMPLE_W;
	localparam int SW = SB + FRACTION_BITS;
	localparam int AW = SB + 16;
	localparam int BW = SW + 16;
	localparam int NW = jac_pkg::MAP_NUM_W;
	localparam int PW = jac_pkg::POS_W;

	jac_pkg::lane_state_e state_q, state_d;

	logic [SW-1:0]  smooth_q;
	logic [SB-1:0]  raw_q;
	logic [AW-1:0]  prod_a_q;
	logic [BW-1:0]  prod_b_q;
	logic           neg_q;
	logic           zero_span;
	logic signed [PW-1:0] result_q;

	logic [BW:0]    sum;
	logic [SB-1:0]  v;
	logic [SB:0]    diff;
	logic [SB:0]    span;
	logic [SB-1:0]  abs_diff;
	logic [SB-1:0]  abs_span;
	logic [NW-1:0]  num_mag;
	logic           div_start;
	logic           div_busy;
	logic [NW-1:0]  quot;
	logic [PW-1:0]  q8;
	logic [PW-1:0]  mag;
	logic signed [PW-1:0] mapped;

	// filter: s' = (alpha*raw_q + (1-alpha)*s) >> 16
	assign sum = ((BW+1)'(prod_a_q) << FRACTION_BITS) + (BW+1)'(prod_b_q);

	assign v        = smooth_q[FRACTION_BITS +: SB];
	assign diff     = {1'b0, v} - {1'b0, cfg.lo};
	assign span     = {1'b0, cfg.hi} - {1'b0, cfg.lo};
	assign abs_diff = diff[SB] ? SB'(-diff) : diff[SB-1:0];
	assign abs_span = span[SB] ? SB'(-span) : span[SB-1:0];
	assign num_mag  = NW'(NW'(abs_diff) * NW'(jac_pkg::MAP_SCALE));
	assign zero_span = span == '0;
	assign div_start = (state_q == jac_pkg::LS_PRE) && !zero_span;

	jac_div #(
		.NUM_W(NW),
		.DEN_W(SB)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.numer (num_mag),
		.denom (abs_span),
		.busy  (div_busy),
		.quot  (quot)
	);

	// negative quotient clamps to the low end and large ones to the high end, unless the dead band covers them
	always_comb begin
		q8     = quot[PW-1:0];
		mag    = PW'(jac_pkg::OUT_SPAN);
		mapped = -PW'(jac_pkg::OUT_SPAN);
		if (!neg_q) begin
			if (quot >= NW'(2 * jac_pkg::OUT_SPAN)) begin
				mapped = PW'(jac_pkg::OUT_SPAN);
			end else begin
				mapped = $signed(q8 - PW'(jac_pkg::OUT_SPAN));
				mag = (q8 >= PW'(jac_pkg::OUT_SPAN)) ? q8 - PW'(jac_pkg::OUT_SPAN)
					: PW'(jac_pkg::OUT_SPAN) - q8;
			end
		end
		if (mag < PW'(cfg.dead)) begin
			mapped = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jac_pkg::LS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			jac_pkg::LS_IDLE, jac_pkg::LS_DONE: begin
				if (ctl.start) state_d = jac_pkg::LS_MUL;
			end
			jac_pkg::LS_MUL:  state_d = jac_pkg::LS_ADD;
			jac_pkg::LS_ADD:  state_d = jac_pkg::LS_PRE;
			jac_pkg::LS_PRE:  state_d = zero_span ? jac_pkg::LS_DONE : jac_pkg::LS_DIV;
			jac_pkg::LS_DIV: begin
				if (!div_busy) state_d = jac_pkg::LS_POST;
			end
			jac_pkg::LS_POST: state_d = jac_pkg::LS_DONE;
			default:          state_d = jac_pkg::LS_IDLE;
		endcase
	end

	// filter state is architectural, so it resets to the centre
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q <= SW'(jac_pkg::RST_REST) << FRACTION_BITS;
		end else if (ctl.load) begin
			smooth_q <= SW'(ctl.rest) << FRACTION_BITS;
		end else if (state_q == jac_pkg::LS_ADD) begin
			smooth_q <= sum[16 +: SW];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			raw_q <= raw;
		end
		if (state_q == jac_pkg::LS_MUL) begin
			prod_a_q <= AW'(AW'(jac_pkg::ALPHA_Q16) * AW'(raw_q));
			prod_b_q <= BW'(BW'(jac_pkg::ONE_MINUS_Q16) * BW'(smooth_q));
		end
		if (state_q == jac_pkg::LS_PRE) begin
			neg_q <= diff[SB] ^ span[SB];
			if (zero_span) result_q <= '0;
		end
		if (state_q == jac_pkg::LS_POST) begin
			result_q <= mapped;
		end
	end

	assign done   = state_q == jac_pkg::LS_DONE;
	assign result = result_q;

endmodule

[rtl/joystick_axis_conditioner_unit.sv]
`timescale 1ns / 1ps
// Joystick axis conditioner. Each request carries two 12-bit axis samples, a button
// level and a potentiometer sample, and yields exactly one conditioned result.
// Two axis lanes run side by side: each smooths its axis with an exponential filter
// (alpha 13107/65536, unsigned fixed point with FRACTION_BITS fraction bits), maps the
// integer part of the filter value from the calibrated low/high bounds onto -100..100
// with truncating division, clamps it, and zeroes it inside the axis dead band. The pot
// is scaled onto 1..50 when the request is taken, dividing by 4095 with a shift and add;
// the merge stage collects both lanes into the output register, together with the pot
// sensitivity and the button level passed through.
// An item occupies the block in these steps: the filter multiply and add states, a setup
// state, the serial divider of each lane (one quotient bit per cycle) and the cycle in which
// it reports done, a finishing state and a merge cycle that loads the output register;
// the next request is taken in the cycle after that, even while the previous result still
// waits to be taken. The merge cycle stretches while an earlier result is still stalled in
// the output register. With a zero span on both axes the dividers are skipped.
// A zero span gives 0 on that axis. Writing x_rest or y_rest reloads that axis's filter
// state with the new centre. Registers sit at byte address 4*index, reset to 0, 4095,
// 0, 4095, 2048, 2048, 20, 25; write them only while no request is in flight.

module joystick_axis_conditioner_unit #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// request channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  jac_pkg::in_item_t                   in_data,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output jac_pkg::out_item_t                  out_data,
	// configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [jac_pkg::CFG_ADDR_W-1:0]      paddr,
	input  logic [jac_pkg::CFG_DATA_W-1:0]      pwdata,
	output logic [jac_pkg::CFG_DATA_W-1:0]      prdata,
	output logic                                pready
);

	localparam int SB = jac_pkg::SAMPLE_W;
	localparam int DW = jac_pkg::DEAD_W;

	// configuration registers
	logic [SB-1:0] x_low_q, x_high_q, y_low_q, y_high_q, x_rest_q, y_rest_q;
	logic [DW-1:0] x_dead_q, y_dead_q;

	jac_pkg::top_state_e state_q, state_d;
	jac_pkg::cfg_idx_e   cfg_idx;
	jac_pkg::lane_ctl_t  x_ctl, y_ctl;
	jac_pkg::axis_cfg_t  x_cfg, y_cfg;
	jac_pkg::out_item_t  out_q;

	logic cfg_wr;
	logic accept;
	logic slot_free;
	logic all_done;
	logic load_out;
	logic out_valid_q;
	logic button_q;

	logic x_done, y_done;
	logic signed [jac_pkg::POS_W-1:0] x_res, y_res;

	logic [jac_pkg::POT_NUM_W-1:0] pot_num;
	logic [jac_pkg::POT_NUM_W-1:0] pot_sum;
	logic [jac_pkg::SENS_W-1:0]    sens_q;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = jac_pkg::cfg_idx_e'(paddr[2 +: jac_pkg::CFG_IDX_W]);

	// register file: dead band fields keep the low seven bits, the rest twelve
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_low_q  <= jac_pkg::RST_LOW;
			x_high_q <= jac_pkg::RST_HIGH;
			y_low_q  <= jac_pkg::RST_LOW;
			y_high_q <= jac_pkg::RST_HIGH;
			x_rest_q <= jac_pkg::RST_REST;
			y_rest_q <= jac_pkg::RST_REST;
			x_dead_q <= jac_pkg::RST_X_DEAD;
			y_dead_q <= jac_pkg::RST_Y_DEAD;
		end else if (cfg_wr) begin
			case (cfg_idx)
				jac_pkg::REG_X_LOW:  x_low_q  <= pwdata[SB-1:0];
				jac_pkg::REG_X_HIGH: x_high_q <= pwdata[SB-1:0];
				jac_pkg::REG_Y_LOW:  y_low_q  <= pwdata[SB-1:0];
				jac_pkg::REG_Y_HIGH: y_high_q <= pwdata[SB-1:0];
				jac_pkg::REG_X_REST: x_rest_q <= pwdata[SB-1:0];
				jac_pkg::REG_Y_REST: y_rest_q <= pwdata[SB-1:0];
				jac_pkg::REG_X_DEAD: x_dead_q <= pwdata[DW-1:0];
				jac_pkg::REG_Y_DEAD: y_dead_q <= pwdata[DW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (cfg_idx)
			jac_pkg::REG_X_LOW:  prdata = jac_pkg::CFG_DATA_W'(x_low_q);
			jac_pkg::REG_X_HIGH: prdata = jac_pkg::CFG_DATA_W'(x_high_q);
			jac_pkg::REG_Y_LOW:  prdata = jac_pkg::CFG_DATA_W'(y_low_q);
			jac_pkg::REG_Y_HIGH: prdata = jac_pkg::CFG_DATA_W'(y_high_q);
			jac_pkg::REG_X_REST: prdata = jac_pkg::CFG_DATA_W'(x_rest_q);
			jac_pkg::REG_Y_REST: prdata = jac_pkg::CFG_DATA_W'(y_rest_q);
			jac_pkg::REG_X_DEAD: prdata = jac_pkg::CFG_DATA_W'(x_dead_q);
			jac_pkg::REG_Y_DEAD: prdata = jac_pkg::CFG_DATA_W'(y_dead_q);
			default:             prdata = '0;
		endcase
	end

	// request side: one item in flight, taken only while idle
	assign in_stall = state_q == jac_pkg::ST_RUN;
	assign accept   = in_valid && !in_stall;

	// a rest write reloads the lane's filter state straight from the bus
	always_comb begin
		x_ctl.start = accept;
		x_ctl.load  = cfg_wr && (cfg_idx == jac_pkg::REG_X_REST);
		x_ctl.rest  = pwdata[SB-1:0];
		y_ctl.start = accept;
		y_ctl.load  = cfg_wr && (cfg_idx == jac_pkg::REG_Y_REST);
		y_ctl.rest  = pwdata[SB-1:0];
		x_cfg.lo    = x_low_q;
		x_cfg.hi    = x_high_q;
		x_cfg.dead  = x_dead_q;
		y_cfg.lo    = y_low_q;
		y_cfg.hi    = y_high_q;
		y_cfg.dead  = y_dead_q;
	end

	jac_lane #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_lane_x (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (x_ctl),
		.cfg   (x_cfg),
		.raw   (in_data.raw_x),
		.done  (x_done),
		.result(y_res == y_res ? x_res : x_res)
	);

	jac_lane #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_lane_y (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (y_ctl),
		.cfg   (y_cfg),
		.raw   (in_data.raw_y),
		.done  (y_done),
		.result(y_res)
	);

	// pot * 49 / 4095, truncating; with 4095 = 2^12 - 1 the quotient is
	// (n + (n >> 12) + 1) >> 12, exact while the quotient stays small
	assign pot_num = jac_pkg::POT_NUM_W'(jac_pkg::POT_NUM_W'(in_data.pot_level)
		* jac_pkg::POT_NUM_W'(jac_pkg::POT_SCALE));
	assign pot_sum = pot_num + (pot_num >> SB) + jac_pkg::POT_NUM_W'(1);

	always_ff @(posedge clk) begin
		if (accept) begin
			button_q <= in_data.button_level;
			sens_q   <= pot_sum[SB +: jac_pkg::SENS_W] + jac_pkg::SENS_MIN;
		end
	end

	// merge: wait for both lanes, and for room in the output register
	assign slot_free = !out_valid_q || !out_stall;
	assign all_done  = x_done && y_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jac_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		case (state_q)
			jac_pkg::ST_IDLE: begin
				if (accept) state_d = jac_pkg::ST_RUN;
			end
			jac_pkg::ST_RUN: begin
				if (all_done && slot_free) begin
					load_out = 1'b1;
					state_d  = jac_pkg::ST_IDLE;
				end
			end
			default: state_d = jac_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.x_position        <= x_res;
			out_q.y_position        <= y_res;
			out_q.button_state      <= button_q;
			out_q.sensitivity_level <= sens_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[rtl/jac_checker.sv]
`timescale 1ns / 1ps
// port-level checker for the joystick axis conditioner, bound to the top level
// depends on jac_pkg and joystick_axis_conditioner_unit

module jac_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input jac_pkg::out_item_t out_data
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// a taken request blocks the next one while it is worked on
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while previous still in flight");

	// a new result only appears after a request was being worked on
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without request");

	// axis outputs stay within the mapped range
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.x_position >= -8'sd100) && (out_data.x_position <= 8'sd100)
			&& (out_data.y_position >= -8'sd100) && (out_data.y_position <= 8'sd100))
		else $error("axis position out of range");

	// sensitivity stays within 1..50
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.sensitivity_level >= 6'd1)
			&& (out_data.sensitivity_level <= 6'd50))
		else $error("sensitivity out of range");

endmodule

bind joystick_axis_conditioner_unit jac_checker u_jac_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data (out_data)
);
